FILE: sv/buddy_block_allocator_core_assert.svh
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Check on every clock outside reset.
`define BBAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock, reset included.
`define BBAC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bbac_pkg.sv
package bbac_pkg;

  localparam int LEVELS       = 8;
  localparam int MIN_SHIFT    = 5;
  localparam int PAGE_BYTES   = 4096;
  localparam int NUM_PAGES    = 16;
  localparam int HEADER_BYTES = 24;

  localparam int PAGE_UNITS = ((PAGE_BYTES >> MIN_SHIFT) != 0) ? (PAGE_BYTES >> MIN_SHIFT) : 1;
  localparam int NUM_UNITS  = NUM_PAGES * PAGE_UNITS;
  localparam int TOP        = LEVELS - 1;

  localparam int UNIT_W   = $clog2(NUM_UNITS);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int PAGE_W   = $clog2(NUM_PAGES);
  localparam int PG_SHIFT = $clog2(PAGE_UNITS);

  localparam int SIZE_W = 13;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 2;
  localparam int TOT_W  = SIZE_W + 1;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic              alloc;
    logic              nv;
    logic              pv;
    logic [UNIT_W-1:0] next;
    logic [UNIT_W-1:0] prev;
  } hdr_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_A_HDR,
    S_UL_N,
    S_UL_NW,
    S_UL_P,
    S_UL_PW,
    S_SPLIT,
    S_PU_W,
    S_PU_R,
    S_PU_M,
    S_F_HDR,
    S_F_LOOP,
    S_F_SIB,
    S_F_MRG,
    S_F_END,
    S_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SET_RES,
    OP_A_POP,
    OP_A_PAGE,
    OP_LOAD_LH,
    OP_UL_RDN,
    OP_UL_WRN,
    OP_UL_RDP,
    OP_UL_WRP,
    OP_UL_HEAD,
    OP_SPLIT,
    OP_PU_W,
    OP_PU_R,
    OP_PU_M,
    OP_A_FINAL,
    OP_F_START,
    OP_F_LOAD,
    OP_F_RDSIB,
    OP_F_MRG,
    OP_F_PAGE,
    OP_F_PUSH,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic lv_ok;
    logic found;
    logic page_avail;
    logic free_ok;
    logic lh_nv;
    logic lh_pv;
    logic split_more;
    logic push_link;
    logic rd_alloc;
    logic sib_match;
    logic at_top;
    logic top_valid;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: sv/bbac_ctrl.sv
module bbac_ctrl
  import bbac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_op_t   op
);

  state_t state;
  state_t state_next;
  state_t ret_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    ret_state  = st.is_free ? S_F_MRG : S_SPLIT;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_free) begin
          if (st.free_ok) begin
            op         = OP_F_START;
            state_next = S_F_HDR;
          end else begin
            state_next = S_RESP;
          end
        end else if (st.size_zero || !st.lv_ok || (!st.found && !st.page_avail)) begin
          op         = OP_SET_RES;
          state_next = S_RESP;
        end else if (st.found) begin
          op         = OP_A_POP;
          state_next = S_A_HDR;
        end else begin
          op         = OP_A_PAGE;
          state_next = S_SPLIT;
        end
      end
      S_A_HDR: begin
        op         = OP_LOAD_LH;
        state_next = S_UL_N;
      end
      S_UL_N: begin
        if (st.lh_nv) begin
          op         = OP_UL_RDN;
          state_next = S_UL_NW;
        end else begin
          state_next = S_UL_P;
        end
      end
      S_UL_NW: begin
        op         = OP_UL_WRN;
        state_next = S_UL_P;
      end
      S_UL_P: begin
        if (st.lh_pv) begin
          op         = OP_UL_RDP;
          state_next = S_UL_PW;
        end else begin
          op         = OP_UL_HEAD;
          state_next = ret_state;
        end
      end
      S_UL_PW: begin
        op         = OP_UL_WRP;
        state_next = ret_state;
      end
      S_SPLIT: begin
        if (st.split_more) begin
          op         = OP_SPLIT;
          state_next = S_PU_W;
        end else begin
          op         = OP_A_FINAL;
          state_next = S_RESP;
        end
      end
      S_PU_W: begin
        op = OP_PU_W;
        if (st.push_link) begin
          state_next = S_PU_R;
        end else begin
          state_next = st.is_free ? S_RESP : S_SPLIT;
        end
      end
      S_PU_R: begin
        op         = OP_PU_R;
        state_next = S_PU_M;
      end
      S_PU_M: begin
        op         = OP_PU_M;
        state_next = st.is_free ? S_RESP : S_SPLIT;
      end
      S_F_HDR: begin
        if (st.rd_alloc) begin
          op         = OP_F_LOAD;
          state_next = S_F_LOOP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_F_LOOP: begin
        if (st.at_top) begin
          state_next = S_F_END;
        end else begin
          op         = OP_F_RDSIB;
          state_next = S_F_SIB;
        end
      end
      S_F_SIB: begin
        if (st.sib_match) begin
          op         = OP_LOAD_LH;
          state_next = S_UL_N;
        end else begin
          state_next = S_F_END;
        end
      end
      S_F_MRG: begin
        op         = OP_F_MRG;
        state_next = S_F_LOOP;
      end
      S_F_END: begin
        if (st.at_top && st.top_valid) begin
          op         = OP_F_PAGE;
          state_next = S_RESP;
        end else begin
          op         = OP_F_PUSH;
          state_next = S_PU_W;
        end
      end
      S_RESP: begin
        if (!st.out_busy) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bbac_datapath.sv
module bbac_datapath
  import bbac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_op_t            op,
  output dp_stat_t          st,
  input  logic              req_type,
  input  logic [SIZE_W-1:0] alloc_size,
  input  logic [ADDR_W-1:0] free_addr,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ADDR_W-1:0] user_addr,
  output logic [STAT_W-1:0] status
);

  hdr_t mem [NUM_UNITS];
  hdr_t rdata;
  logic              mem_we;
  logic [UNIT_W-1:0] mem_addr;
  hdr_t              mem_wdata;

  logic [UNIT_W-1:0] head [LEVELS];
  logic [LEVELS-1:0] head_valid;
  logic [NUM_PAGES-1:0] page_in_use;

  logic              req_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;

  logic [UNIT_W-1:0] u;
  logic [LVL_W-1:0]  cur_lvl;
  logic [LVL_W-1:0]  tgt_lvl;
  hdr_t              lh;
  hdr_t              cur;
  logic [UNIT_W-1:0] pu;
  logic [LVL_W-1:0]  pl;
  logic [UNIT_W-1:0] oh;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  // request decode
  logic [TOT_W-1:0]  total;
  logic [LVL_W-1:0]  lv;
  logic              lv_ok;
  logic [LVL_W-1:0]  p_found;
  logic              found;
  logic [PAGE_W-1:0] page_idx;
  logic              page_avail;
  logic [ADDR_W-1:0] base;
  logic [UNIT_W-1:0] fu;
  logic              free_ok;
  logic [UNIT_W-1:0] bit_mask;
  logic [LVL_W-1:0]  lvl_dn;
  status_t           dec_status;
  hdr_t              mrg_hdr;

  always_comb begin
    total = TOT_W'(size_q) + TOT_W'(HEADER_BYTES);
    lv    = LVL_W'(TOP);
    lv_ok = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((TOT_W'(1) << (MIN_SHIFT + l)) >= total) begin
        lv    = LVL_W'(l);
        lv_ok = 1'b1;
      end
    end
    p_found = '0;
    found   = 1'b0;
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (head_valid[p] && (LVL_W'(p) >= lv)) begin
        p_found = LVL_W'(p);
        found   = 1'b1;
      end
    end
    page_idx   = '0;
    page_avail = 1'b0;
    for (int k = NUM_PAGES - 1; k >= 0; k--) begin
      if (!page_in_use[k]) begin
        page_idx   = PAGE_W'(k);
        page_avail = 1'b1;
      end
    end
    base    = addr_q - ADDR_W'(HEADER_BYTES);
    fu      = base[ADDR_W-1:MIN_SHIFT];
    free_ok = (addr_q >= ADDR_W'(HEADER_BYTES)) && (base[MIN_SHIFT-1:0] == '0) &&
              page_in_use[fu[UNIT_W-1:PG_SHIFT]];
    bit_mask = UNIT_W'(1) << cur_lvl;
    lvl_dn   = cur_lvl - LVL_W'(1);
    // merged block header: the lower half's, one level up
    if ((u & bit_mask) != '0) begin
      mrg_hdr    = lh;
      mrg_hdr.nv = 1'b0;
      mrg_hdr.pv = 1'b0;
    end else begin
      mrg_hdr = cur;
    end
    mrg_hdr.alloc = 1'b0;
    mrg_hdr.level = cur_lvl + LVL_W'(1);
    if (size_q == '0) begin
      dec_status = ST_ZERO;
    end else if (!lv_ok) begin
      dec_status = ST_TOO_LARGE;
    end else begin
      dec_status = ST_EXHAUSTED;
    end
  end

  always_comb begin
    st.is_free    = (req_q == REQ_FREE);
    st.size_zero  = (size_q == '0);
    st.lv_ok      = lv_ok;
    st.found      = found;
    st.page_avail = page_avail;
    st.free_ok    = free_ok;
    st.lh_nv      = lh.nv;
    st.lh_pv      = lh.pv;
    st.split_more = (cur_lvl > tgt_lvl);
    st.push_link  = head_valid[pl];
    st.rd_alloc   = rdata.alloc;
    st.sib_match  = !rdata.alloc && (rdata.level == cur_lvl);
    st.at_top     = (cur_lvl == LVL_W'(TOP));
    st.top_valid  = head_valid[TOP];
    st.out_busy   = out_valid && !out_ready;
  end

  // header memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = u;
    mem_wdata = rdata;
    case (op)
      OP_A_POP:   mem_addr = head[p_found];
      OP_UL_RDN:  mem_addr = lh.next;
      OP_UL_WRN: begin
        mem_we         = 1'b1;
        mem_addr       = lh.next;
        mem_wdata.pv   = lh.pv;
        mem_wdata.prev = lh.prev;
      end
      OP_UL_RDP:  mem_addr = lh.prev;
      OP_UL_WRP: begin
        mem_we         = 1'b1;
        mem_addr       = lh.prev;
        mem_wdata.nv   = lh.nv;
        mem_wdata.next = lh.next;
      end
      OP_PU_W: begin
        mem_we          = 1'b1;
        mem_addr        = pu;
        mem_wdata.level = pl;
        mem_wdata.alloc = 1'b0;
        mem_wdata.nv    = head_valid[pl];
        mem_wdata.pv    = 1'b0;
        mem_wdata.next  = head[pl];
        mem_wdata.prev  = '0;
      end
      OP_PU_R:    mem_addr = oh;
      OP_PU_M: begin
        mem_we         = 1'b1;
        mem_addr       = oh;
        mem_wdata.pv   = 1'b1;
        mem_wdata.prev = pu;
      end
      OP_A_FINAL: begin
        mem_we          = 1'b1;
        mem_wdata.level = tgt_lvl;
        mem_wdata.alloc = 1'b1;
        mem_wdata.nv    = 1'b0;
        mem_wdata.pv    = 1'b0;
        mem_wdata.next  = '0;
        mem_wdata.prev  = '0;
      end
      OP_F_START: mem_addr = fu;
      OP_F_RDSIB: mem_addr = u ^ bit_mask;
      OP_F_MRG: begin
        // upper half absorbed: mark its header free
        mem_we          = ((u & bit_mask) != '0);
        mem_wdata       = cur;
        mem_wdata.alloc = 1'b0;
      end
      OP_F_PAGE: begin
        mem_we          = 1'b1;
        mem_wdata       = cur;
        mem_wdata.alloc = 1'b0;
        mem_wdata.nv    = 1'b0;
        mem_wdata.pv    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= '0;
      page_in_use <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_A_PAGE:  page_in_use[page_idx] <= 1'b1;
        OP_UL_HEAD: head_valid[cur_lvl] <= lh.nv;
        OP_PU_W:    head_valid[pl] <= 1'b1;
        OP_F_PAGE:  page_in_use[u[UNIT_W-1:PG_SHIFT]] <= 1'b0;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        req_q      <= req_type;
        size_q     <= alloc_size;
        addr_q     <= free_addr;
        res_addr   <= '0;
        res_status <= ST_OK;
      end
      OP_SET_RES: res_status <= dec_status;
      OP_A_POP: begin
        u       <= head[p_found];
        cur_lvl <= p_found;
        tgt_lvl <= lv;
      end
      OP_A_PAGE: begin
        u       <= {page_idx, {PG_SHIFT{1'b0}}};
        cur_lvl <= LVL_W'(TOP);
        tgt_lvl <= lv;
      end
      OP_LOAD_LH: lh <= rdata;
      OP_UL_HEAD: head[cur_lvl] <= lh.next;
      OP_SPLIT: begin
        cur_lvl <= lvl_dn;
        pl      <= lvl_dn;
        pu      <= u + (UNIT_W'(1) << lvl_dn);
      end
      OP_PU_W: begin
        oh       <= head[pl];
        head[pl] <= pu;
      end
      OP_A_FINAL: begin
        res_addr   <= ADDR_W'({u, {MIN_SHIFT{1'b0}}}) + ADDR_W'(HEADER_BYTES);
        res_status <= ST_OK;
      end
      OP_F_START: u <= fu;
      OP_F_LOAD: begin
        cur     <= rdata;
        cur_lvl <= rdata.level;
      end
      OP_F_MRG: begin
        cur     <= mrg_hdr;
        u       <= u & ~bit_mask;
        cur_lvl <= cur_lvl + LVL_W'(1);
      end
      OP_F_PUSH: begin
        pu <= u;
        pl <= cur_lvl;
      end
      OP_OUT: begin
        user_addr <= res_addr;
        status    <= res_status;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/buddy_block_allocator_core.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | req_type, alloc_size, free_addr
// out     | output    | out_valid/out_ready | user_addr, status
//
// One request is worked at a time; a rejected request goes from decode straight to
// the response state. Each level walked costs a split push with list link, or a
// buddy read, unlink and merge on the single-port header memory.
// The next request is taken while the result waits in the output register.
// rst clears state, free lists and page map; the header memory is not cleared.
module buddy_block_allocator_core
  import bbac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [SIZE_W-1:0] alloc_size,
  input  logic [ADDR_W-1:0] free_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] user_addr,
  output logic [STAT_W-1:0] status
);

  dp_op_t   op;
  dp_stat_t st;

  bbac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  bbac_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .req_type   (req_type),
    .alloc_size (alloc_size),
    .free_addr  (free_addr),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .user_addr  (user_addr),
    .status     (status)
  );

endmodule

FILE: sv/bbac_checker.sv
`include "buddy_block_allocator_core_assert.svh"

module bbac_checker
  import bbac_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] user_addr,
  input logic [STAT_W-1:0] status
);

  logic [ADDR_W-1:0] ub;
  assign ub = user_addr - ADDR_W'(HEADER_BYTES);

  `BBAC_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !out_valid, "output valid right after reset")
  `BBAC_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "took a second transaction")
  `BBAC_ASSERT(a_fail_addr_zero, (out_valid && (status != ST_OK)) |-> (user_addr == '0), "failed transaction carries an address")
  `BBAC_ASSERT(a_addr_aligned, (out_valid && (user_addr != '0)) |-> (ub[MIN_SHIFT-1:0] == '0), "block address not unit aligned")
  `BBAC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

endmodule

bind buddy_block_allocator_core bbac_checker u_chk (.*);
